>>> hw/rtl/lps_pkg.sv
// Shared types for the level pair selector: controller states and the
// command and status groups between controller and datapath.
// Depends on nothing; all files but lps_checker use its scoped names.
package lps_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_I,
    S_LD_I,
    S_CMP,
    S_OUT_I,
    S_OUT_J,
    S_OUT_NONE
  } lps_state_t;

  typedef struct packed {
    logic accept;
    logic rd_i;
    logic ld_i;
    logic cmp_next;
    logic next_i;
    logic emit_i;
    logic emit_j;
    logic emit_none;
  } lps_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic hit;
    logic j_last;
    logic i_more;
  } lps_status_t;

endpackage

>>> hw/rtl/lps_ctrl.sv
// Controller state machine of the level pair selector.
// Depends on lps_pkg; drives commands to lps_datapath and reads its status.
module lps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                list_end,
  input  lps_pkg::lps_status_t sts,
  output logic                busy,
  output lps_pkg::lps_cmd_t   cmd
);

  lps_pkg::lps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lps_pkg::S_IDLE: begin
        if (start && list_end) state_nxt = lps_pkg::S_RD_I;
      end
      lps_pkg::S_RD_I: begin
        state_nxt = sts.n_lt2 ? lps_pkg::S_OUT_NONE : lps_pkg::S_LD_I;
      end
      lps_pkg::S_LD_I: begin
        state_nxt = lps_pkg::S_CMP;
      end
      lps_pkg::S_CMP: begin
        priority if (sts.hit) begin
          state_nxt = lps_pkg::S_OUT_I;
        end else if (sts.j_last) begin
          state_nxt = sts.i_more ? lps_pkg::S_RD_I : lps_pkg::S_OUT_NONE;
        end else begin
          state_nxt = lps_pkg::S_CMP;
        end
      end
      lps_pkg::S_OUT_I:    state_nxt = lps_pkg::S_OUT_J;
      lps_pkg::S_OUT_J:    state_nxt = lps_pkg::S_IDLE;
      lps_pkg::S_OUT_NONE: state_nxt = lps_pkg::S_IDLE;
      default:             state_nxt = lps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      lps_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      lps_pkg::S_RD_I: cmd.rd_i = 1'b1;
      lps_pkg::S_LD_I: cmd.ld_i = 1'b1;
      lps_pkg::S_CMP: begin
        cmd.next_i   = !sts.hit && sts.j_last && sts.i_more;
        cmd.cmp_next = !sts.hit && !sts.j_last;
      end
      lps_pkg::S_OUT_I:    cmd.emit_i = 1'b1;
      lps_pkg::S_OUT_J:    cmd.emit_j = 1'b1;
      lps_pkg::S_OUT_NONE: cmd.emit_none = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule

>>> hw/rtl/lps_datapath.sv
// Datapath of the level pair selector: rectangle memory, pair counters,
// slope compare and the result register.
// Depends on lps_pkg; steered by lps_ctrl.
module lps_datapath #(
  parameter int MAX_RECTS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lps_pkg::lps_cmd_t     cmd,
  input  logic [COORD_BITS-1:0] in_rect_x,
  input  logic [COORD_BITS-1:0] in_rect_y,
  input  logic [COORD_BITS-1:0] in_rect_width,
  input  logic [COORD_BITS-1:0] in_rect_height,
  input  logic                  in_list_end,
  output lps_pkg::lps_status_t  sts,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_width,
  output logic [COORD_BITS-1:0] out_height,
  output logic                  out_final_result,
  output logic                  out_dropped
);

  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int MW = COORD_BITS + 1;
  localparam int RW = 4 * COORD_BITS;
  localparam int EW = RW + 2 * MW;

  logic [EW-1:0] mem [MAX_RECTS];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          rd_en;

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [IW-1:0] i_r, j_r;
  logic [RW-1:0] rect_i_r;
  logic [MW-1:0] mx_i_r, my_i_r;

  logic          has_room;
  logic [MW:0]   sum_x, sum_y;
  logic [EW-1:0] wr_entry;

  logic [MW-1:0] mx_j, my_j, dx, dy;
  logic [MW+2:0] dy5, dx2;

  logic              out_valid_r, out_found_r, out_final_r, out_dropped_r;
  logic [RW-1:0]     out_rect_r;

  assign has_room = count_r < CW'(MAX_RECTS);

  // Midpoints are (2*x + w) >> 1, kept one bit wider than a coordinate.
  assign sum_x    = {1'b0, in_rect_x, 1'b0} + {2'b00, in_rect_width};
  assign sum_y    = {1'b0, in_rect_y, 1'b0} + {2'b00, in_rect_height};
  assign wr_entry = {in_rect_x, in_rect_y, in_rect_width, in_rect_height,
                     sum_x[MW:1], sum_y[MW:1]};

  always_ff @(posedge clk) begin
    if (cmd.accept && has_room) begin
      mem[count_r[IW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    rd_en   = cmd.rd_i || cmd.ld_i || cmd.cmp_next;
    rd_addr = i_r;
    priority if (cmd.ld_i) begin
      rd_addr = i_r + IW'(1);
    end else if (cmd.cmp_next) begin
      rd_addr = j_r + IW'(1);
    end else begin
      rd_addr = i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.emit_j || cmd.emit_none) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (has_room) begin
        count_r <= count_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.accept && in_list_end) begin
        i_r <= '0;
      end else if (cmd.next_i) begin
        i_r <= i_r + IW'(1);
      end
      if (cmd.ld_i) begin
        j_r <= i_r + IW'(1);
      end else if (cmd.cmp_next) begin
        j_r <= j_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_i) begin
      rect_i_r <= rd_data_r[EW-1 -: RW];
      mx_i_r   <= rd_data_r[2*MW-1 -: MW];
      my_i_r   <= rd_data_r[MW-1:0];
    end
  end

  // Level test in integers: 5*|dy| < 2*|dx| with dx nonzero.
  assign mx_j = rd_data_r[2*MW-1 -: MW];
  assign my_j = rd_data_r[MW-1:0];
  assign dx   = (mx_i_r > mx_j) ? (mx_i_r - mx_j) : (mx_j - mx_i_r);
  assign dy   = (my_i_r > my_j) ? (my_i_r - my_j) : (my_j - my_i_r);
  assign dy5  = {1'b0, dy, 2'b00} + {3'b000, dy};
  assign dx2  = {2'b00, dx, 1'b0};

  assign sts.hit    = (dx != '0) && (dy5 < dx2);
  assign sts.n_lt2  = count_r < CW'(2);
  assign sts.j_last = (CW'(j_r) + CW'(1)) == count_r;
  assign sts.i_more = ({1'b0, CW'(i_r)} + (CW+1)'(2)) < {1'b0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_i || cmd.emit_j || cmd.emit_none;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_i || cmd.emit_j || cmd.emit_none) begin
      out_found_r   <= !cmd.emit_none;
      out_final_r   <= !cmd.emit_i;
      out_dropped_r <= ovf_r;
      priority if (cmd.emit_i) begin
        out_rect_r <= rect_i_r;
      end else if (cmd.emit_j) begin
        out_rect_r <= rd_data_r[EW-1 -: RW];
      end else begin
        out_rect_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_final_result = out_final_r;
  assign out_dropped      = out_dropped_r;
  assign out_x            = out_rect_r[4*COORD_BITS-1 -: COORD_BITS];
  assign out_y            = out_rect_r[3*COORD_BITS-1 -: COORD_BITS];
  assign out_width        = out_rect_r[2*COORD_BITS-1 -: COORD_BITS];
  assign out_height       = out_rect_r[COORD_BITS-1:0];

endmodule

>>> hw/rtl/level_pair_selector_core.sv
// Top level of the level pair selector: joins lps_ctrl and lps_datapath.
// Depends on lps_pkg, lps_ctrl and lps_datapath.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+--------------------------------------------
//   input    | start, busy          | in_rect_x/y/width/height, in_list_end
//   result   | out_valid (strobe)   | out_found, out_x/y/width/height,
//            |                      | out_final_result, out_dropped
//
// A rectangle that is not last is taken while busy stays low, and the next
// transaction may follow at once. The last rectangle starts the pair search,
// which reads one stored rectangle per cycle from a single-port memory,
// then gives one or two results. Reset is synchronous and clears the count.
// Results appear for one cycle each on the strobe; the receiver cannot stall.
module level_pair_selector_core #(
  parameter int MAX_RECTS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_rect_x,
  input  logic [COORD_BITS-1:0] in_rect_y,
  input  logic [COORD_BITS-1:0] in_rect_width,
  input  logic [COORD_BITS-1:0] in_rect_height,
  input  logic                  in_list_end,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_width,
  output logic [COORD_BITS-1:0] out_height,
  output logic                  out_final_result,
  output logic                  out_dropped
);

  lps_pkg::lps_cmd_t    cmd;
  lps_pkg::lps_status_t sts;

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .list_end (in_list_end),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  lps_datapath #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_list_end      (in_list_end),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_final_result (out_final_result),
    .out_dropped      (out_dropped)
  );

endmodule

>>> hw/rtl/lps_checker.sv
// Port-level checks for the level pair selector, bound to the top level.
// Depends only on the ports of level_pair_selector_core.
module lps_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_list_end,
  input logic                  out_valid,
  input logic                  out_found,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic [COORD_BITS-1:0] out_width,
  input logic [COORD_BITS-1:0] out_height,
  input logic                  out_final_result
);

  // A not-found result is always the only and last one of its list.
  a_none_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_final_result)
    else $error("not-found result without final marker");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_x == '0 && out_y == '0 && out_width == '0 && out_height == '0)
    else $error("not-found result carries a rectangle");

  // The first rectangle of a pair is followed at once by the second.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && !out_final_result |->
      busy ##1 (out_valid && out_found && out_final_result))
    else $error("pair result not completed in the next cycle");

  a_no_result_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_list_end |=> !out_valid)
    else $error("result after a transaction that is not last");

endmodule

bind level_pair_selector_core lps_checker #(
  .COORD_BITS (COORD_BITS)
) u_lps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_list_end      (in_list_end),
  .out_valid        (out_valid),
  .out_found        (out_found),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_width        (out_width),
  .out_height       (out_height),
  .out_final_result (out_final_result)
);
